>>> rtl/multi_pattern_match_star_marker_unit_assert.svh
// Assertion macros for the multi-pattern star marker checker.
// Included by the checker file; needs nothing else.
`ifndef MULTI_PATTERN_MATCH_STAR_MARKER_UNIT_ASSERT_SVH
`define MULTI_PATTERN_MATCH_STAR_MARKER_UNIT_ASSERT_SVH

// same-cycle implication
`define MPMSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// next-cycle implication
`define MPMSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

>>> rtl/mpmsm_pkg.sv
// Shared types and constants for the multi-pattern star marker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpmsm_pkg;

   localparam int NUM_PATTERNS_DEF = 16;
   localparam int MAX_PAT_LEN_DEF  = 32;

   localparam int CNT_CFG_W  = 5;
   localparam int TYPE_W     = 2;
   localparam int SLOT_IN_W  = 4;
   localparam int POS_IN_W   = 5;
   localparam int BYTE_W     = 8;
   localparam int LEN_IN_W   = 6;

   typedef logic [TYPE_W-1:0] req_code_type;
   localparam req_code_type REQ_PAT_BYTE = 2'd0;
   localparam req_code_type REQ_PAT_LEN  = 2'd1;
   localparam req_code_type REQ_TEXT     = 2'd2;

   typedef struct packed {
      logic accept;     // request transaction taken this cycle
      logic rd_en;      // read one dictionary row and its length
      logic pop;        // release oldest held byte into the output register
      logic pop_flush;  // release is part of a flush
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;   // output register can take a byte this cycle
      logic held_full;  // window holds the maximum number of bytes
      logic held_one;   // window holds exactly one byte
   } dp_status_type;

endpackage
`default_nettype wire

>>> rtl/mpmsm_req_if.sv
// Request channel: pattern loads and text bytes.
// Depends on mpmsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mpmsm_req_if;
   import mpmsm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TYPE_W-1:0]    req_type;
   logic [SLOT_IN_W-1:0] pattern_slot;
   logic [POS_IN_W-1:0]  byte_pos;
   logic [BYTE_W-1:0]    byte_value;
   logic [LEN_IN_W-1:0]  pattern_len;
   logic                 last_in;

   modport source (
      output valid, req_type, pattern_slot, byte_pos, byte_value, pattern_len, last_in,
      input  ready
   );
   modport sink (
      input  valid, req_type, pattern_slot, byte_pos, byte_value, pattern_len, last_in,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/mpmsm_rsp_if.sv
// Response channel: released text bytes with star flag.
// Depends on mpmsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mpmsm_rsp_if;
   import mpmsm_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              star_after;
   logic              last_out;

   modport source (output valid, out_byte, star_after, last_out, input ready);
   modport sink   (input valid, out_byte, star_after, last_out, output ready);
endinterface
`default_nettype wire

>>> rtl/mpmsm_datapath.sv
// Datapath: dictionary memory, length table, byte window with star marks,
// row compare and output register. Depends on mpmsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpmsm_datapath #(
   parameter int NUM_PATTERNS = mpmsm_pkg::NUM_PATTERNS_DEF,
   parameter int MAX_PAT_LEN  = mpmsm_pkg::MAX_PAT_LEN_DEF,
   localparam int SLOT_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1,
   localparam int CNT_W  = $clog2(NUM_PATTERNS + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mpmsm_pkg::dp_cmd_type               cmd,
   input  wire logic [SLOT_W-1:0]                   scan_slot,
   input  wire logic [mpmsm_pkg::TYPE_W-1:0]        req_type,
   input  wire logic [mpmsm_pkg::SLOT_IN_W-1:0]     pattern_slot,
   input  wire logic [mpmsm_pkg::POS_IN_W-1:0]      byte_pos,
   input  wire logic [mpmsm_pkg::BYTE_W-1:0]        byte_value,
   input  wire logic [mpmsm_pkg::LEN_IN_W-1:0]      pattern_len,
   input  wire logic                                csr_we,
   input  wire logic [mpmsm_pkg::CNT_CFG_W-1:0]     csr_wdata,
   output mpmsm_pkg::dp_status_type                 status,
   output logic [CNT_W-1:0]                         active_cnt,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [mpmsm_pkg::BYTE_W-1:0]             out_byte,
   output logic                                     star_after,
   output logic                                     last_out
);
   import mpmsm_pkg::*;

   localparam int POS_W  = $clog2(MAX_PAT_LEN);
   localparam int HELD_W = $clog2(MAX_PAT_LEN + 1);

   // dictionary: one row per slot, byte-write, registered row read
   logic [MAX_PAT_LEN-1:0][BYTE_W-1:0] pat_mem [NUM_PATTERNS];
   logic [MAX_PAT_LEN-1:0][BYTE_W-1:0] row_ff;
   logic [HELD_W-1:0]                  row_len_ff;
   logic                               rd_valid_ff;

   logic [HELD_W-1:0]    len_ff [NUM_PATTERNS];
   // window: index 0 is the newest byte
   logic [BYTE_W-1:0]    hist_ff [MAX_PAT_LEN];
   logic [MAX_PAT_LEN-1:0] star_ff;
   logic [HELD_W-1:0]    held_ff;
   logic [CNT_CFG_W-1:0] pcount_ff;

   logic                 rsp_valid_ff;
   logic [BYTE_W-1:0]    out_byte_ff;
   logic                 star_after_ff;
   logic                 last_out_ff;

   logic                 slot_ok;
   logic                 is_pbyte;
   logic                 is_plen;
   logic                 is_text;
   logic                 len_ok;
   logic [SLOT_W-1:0]    slot_idx;
   logic [POS_W-1:0]     pos_idx;
   logic [POS_W-1:0]     pop_idx;
   logic                 match;
   logic [MAX_PAT_LEN-1:0] span_mask;

   assign slot_ok  = int'(pattern_slot) < NUM_PATTERNS;
   assign slot_idx = SLOT_W'(pattern_slot);
   assign pos_idx  = POS_W'(byte_pos);
   assign is_pbyte = cmd.accept && (req_type == REQ_PAT_BYTE) && slot_ok &&
                     (int'(byte_pos) < MAX_PAT_LEN);
   assign is_plen  = cmd.accept && (req_type == REQ_PAT_LEN) && slot_ok;
   assign is_text  = cmd.accept && (req_type == REQ_TEXT);
   assign len_ok   = (int'(pattern_len) >= 2) && (int'(pattern_len) <= MAX_PAT_LEN);
   assign pop_idx  = POS_W'(held_ff - HELD_W'(1));

   always_ff @(posedge clock) begin
      if (is_pbyte) begin
         pat_mem[slot_idx][pos_idx] <= byte_value;
      end
      if (cmd.rd_en) begin
         row_ff     <= pat_mem[scan_slot];
         row_len_ff <= len_ff[scan_slot];
      end
   end

   // pattern byte p lines up with window entry len-1-p
   always_comb begin
      match     = rd_valid_ff && (row_len_ff >= HELD_W'(2)) && (row_len_ff <= held_ff);
      span_mask = '0;
      for (int j = 0; j < MAX_PAT_LEN; j++) begin
         if (j < int'(row_len_ff)) begin
            if (hist_ff[j] != row_ff[POS_W'(int'(row_len_ff) - 1 - j)]) begin
               match = 1'b0;
            end
            if (j > 0) begin
               span_mask[j] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         held_ff      <= '0;
         star_ff      <= '0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_PATTERNS; k++) begin
            len_ff[k] <= '0;
         end
      end else begin
         rd_valid_ff <= cmd.rd_en;
         if (csr_we) begin
            pcount_ff <= csr_wdata;
         end
         if (is_plen) begin
            len_ff[slot_idx] <= len_ok ? HELD_W'(pattern_len) : '0;
         end
         if (is_text) begin
            star_ff <= {star_ff[MAX_PAT_LEN-2:0], 1'b0};
            held_ff <= held_ff + HELD_W'(1);
         end else begin
            if (match) begin
               star_ff <= star_ff | span_mask;
            end
            if (cmd.pop) begin
               held_ff <= held_ff - HELD_W'(1);
            end
         end
         if (cmd.pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_text) begin
         hist_ff[0] <= byte_value;
         for (int j = 1; j < MAX_PAT_LEN; j++) begin
            hist_ff[j] <= hist_ff[j-1];
         end
      end
      if (cmd.pop) begin
         out_byte_ff   <= hist_ff[pop_idx];
         star_after_ff <= star_ff[pop_idx];
         last_out_ff   <= cmd.pop_flush && (held_ff == HELD_W'(1));
      end
   end

   assign active_cnt = (int'(pcount_ff) >= NUM_PATTERNS) ? CNT_W'(NUM_PATTERNS)
                                                         : CNT_W'(pcount_ff);

   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.held_full = (held_ff == HELD_W'(MAX_PAT_LEN));
   assign status.held_one  = (held_ff == HELD_W'(1));

   assign rsp_valid  = rsp_valid_ff;
   assign out_byte   = out_byte_ff;
   assign star_after = star_after_ff;
   assign last_out   = last_out_ff;

endmodule
`default_nettype wire

>>> rtl/mpmsm_ctrl.sv
// Controller: accepts requests, sequences the dictionary scan and byte release.
// Depends on mpmsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpmsm_ctrl #(
   parameter int NUM_PATTERNS = mpmsm_pkg::NUM_PATTERNS_DEF,
   localparam int SLOT_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1,
   localparam int CNT_W  = $clog2(NUM_PATTERNS + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [mpmsm_pkg::TYPE_W-1:0]  req_type,
   input  wire logic                          last_in,
   output logic                               req_ready,
   input  wire mpmsm_pkg::dp_status_type      status,
   input  wire logic [CNT_W-1:0]              active_cnt,
   output mpmsm_pkg::dp_cmd_type              cmd,
   output logic [SLOT_W-1:0]                  scan_slot
);
   import mpmsm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SETTLE,
      S_EMIT,
      S_FLUSH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_flag_ff, last_flag_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_flag_in = last_flag_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_type == REQ_TEXT) begin
                  state_in     = S_SCAN;
                  cnt_in       = '0;
                  last_flag_in = last_in;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff < active_cnt) begin
               cmd.rd_en = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            // marks are final here
            if (last_flag_ff) begin
               state_in = S_FLUSH;
            end else if (status.held_full) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.pop       = 1'b1;
               cmd.pop_flush = 1'b1;
               if (status.held_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         last_flag_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_flag_ff <= last_flag_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign scan_slot = cnt_ff[SLOT_W-1:0];

endmodule
`default_nettype wire

>>> rtl/multi_pattern_match_star_marker_unit.sv
// Multi-pattern star marker: request channel, response channel, count register.
// Uses mpmsm_pkg, mpmsm_req_if, mpmsm_rsp_if, mpmsm_ctrl, mpmsm_datapath.
//
// Usage:
//   req_chan carries pattern byte writes, pattern length writes and text bytes.
//   rsp_chan returns released text bytes in order with a star flag and a last flag.
//   csr_we/csr_wdata set the number of dictionary slots in use; write only while idle.
// Timing:
//   A pattern load is written when taken. A text byte scans N slots, N being the
//   slots in use (min of count and NUM_PATTERNS): one dictionary row is read
//   and compared per cycle on the single memory read port. When the window
//   fills, an emit state releases the oldest byte; on the last text byte the
//   held bytes leave one per cycle while output is free (up to MAX_PAT_LEN).
//   A result shows in the output register in the cycle after its release.
// Reset:
//   Synchronous, active high. Clears lengths, window count, slot count and the
//   output valid. Dictionary bytes are undefined until written; no clearing pass.
// Backpressure:
//   A held output transaction stalls a pending release and, with it, new requests;
//   otherwise pattern loads and new text bytes are taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module multi_pattern_match_star_marker_unit #(
   parameter int NUM_PATTERNS = mpmsm_pkg::NUM_PATTERNS_DEF,
   parameter int MAX_PAT_LEN  = mpmsm_pkg::MAX_PAT_LEN_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mpmsm_req_if.sink                               req_chan,
   mpmsm_rsp_if.source                             rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [mpmsm_pkg::CNT_CFG_W-1:0]    csr_wdata
);
   import mpmsm_pkg::*;

   localparam int SLOT_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int CNT_W  = $clog2(NUM_PATTERNS + 1);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [SLOT_W-1:0] scan_slot;
   logic [CNT_W-1:0]  active_cnt;
   logic              req_ready;
   logic              rsp_valid;
   logic [BYTE_W-1:0] out_byte;
   logic              star_after;
   logic              last_out;

   mpmsm_ctrl #(
      .NUM_PATTERNS (NUM_PATTERNS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_type   (req_chan.req_type),
      .last_in    (req_chan.last_in),
      .req_ready  (req_ready),
      .status     (status),
      .active_cnt (active_cnt),
      .cmd        (cmd),
      .scan_slot  (scan_slot)
   );

   mpmsm_datapath #(
      .NUM_PATTERNS (NUM_PATTERNS),
      .MAX_PAT_LEN  (MAX_PAT_LEN)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .scan_slot    (scan_slot),
      .req_type     (req_chan.req_type),
      .pattern_slot (req_chan.pattern_slot),
      .byte_pos     (req_chan.byte_pos),
      .byte_value   (req_chan.byte_value),
      .pattern_len  (req_chan.pattern_len),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .status       (status),
      .active_cnt   (active_cnt),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_chan.ready),
      .out_byte     (out_byte),
      .star_after   (star_after),
      .last_out     (last_out)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.out_byte   = out_byte;
   assign rsp_chan.star_after = star_after;
   assign rsp_chan.last_out   = last_out;

endmodule
`default_nettype wire

>>> rtl/mpmsm_checker.sv
// Port-level checks for the multi-pattern star marker, bound to the top level.
// Depends on mpmsm_pkg and multi_pattern_match_star_marker_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_pattern_match_star_marker_unit_assert.svh"
module mpmsm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [mpmsm_pkg::TYPE_W-1:0]  req_type,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [mpmsm_pkg::BYTE_W-1:0]  out_byte,
   input wire logic                          star_after,
   input wire logic                          last_out
);
   import mpmsm_pkg::*;

   // a stalled response transaction holds
   `MPMSM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(out_byte) && $stable(star_after) && $stable(last_out))

   // a text byte always starts a scan, so the block is busy the next cycle
   `MPMSM_ASSERT_NXT(a_text_busy, clock, reset,
      req_valid && req_ready && (req_type == REQ_TEXT), !req_ready)

   // the newest byte closes every span, so the final byte never carries a star
   `MPMSM_ASSERT_IMP(a_last_no_star, clock, reset, rsp_valid && last_out, !star_after)

   // reset empties the output register
   `MPMSM_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind multi_pattern_match_star_marker_unit mpmsm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_type   (req_chan.req_type),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .out_byte   (rsp_chan.out_byte),
   .star_after (rsp_chan.star_after),
   .last_out   (rsp_chan.last_out)
);
`default_nettype wire

>>> dv/multi_pattern_match_star_marker_unit_tb.sv
// Self-checking testbench for multi_pattern_match_star_marker_unit: directed table, then
// random pattern loads and text runs; each released byte checked by the table or predictor.
// Depends on mpmsm_pkg, mpmsm_req_if, mpmsm_rsp_if and the unit itself.
`timescale 1ns / 1ps
module multi_pattern_match_star_marker_unit_tb;
   import mpmsm_pkg::*;

   localparam int NP           = NUM_PATTERNS_DEF;
   localparam int MAXL         = MAX_PAT_LEN_DEF;
   localparam int SETTLE_CYC   = 48;
   localparam int RUN_LIMIT_NS = 5_000_000;
   localparam req_code_type REQ_RESERVED = 2'd3;
   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_B = 8'h62;

   typedef struct packed {
      req_code_type         kind;
      logic [SLOT_IN_W-1:0] slot;
      logic [POS_IN_W-1:0]  pos;
      logic [BYTE_W-1:0]    val;
      logic [LEN_IN_W-1:0]  plen;
      logic                 last;
   } mpm_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      logic              star;
      logic              fin;
   } released_type;

   // lit: expectation typed in here; lit_res: one byte comes back (the value, marked last)
   typedef struct packed {
      req_code_type         kind;
      logic [SLOT_IN_W-1:0] slot;
      logic [POS_IN_W-1:0]  pos;
      logic [BYTE_W-1:0]    val;
      logic [LEN_IN_W-1:0]  plen;
      logic                 last;
      logic                 lit;
      logic                 lit_res;
      logic                 lit_star;
   } dir_row_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CNT_CFG_W-1:0]       csr_wdata;

   mpmsm_req_if req_chan();
   mpmsm_rsp_if rsp_chan();

   multi_pattern_match_star_marker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   bit [7:0]  pat_mem [NP][MAXL];
   bit        seen [NP][MAXL];
   bit [5:0]  pat_len [NP];
   bit [7:0]  win_ch [MAXL];
   bit        win_star [MAXL];
   int        win_fill;
   int        slots_on;

   released_type pending_rel [$];
   released_type fresh_rel [$];
   int        mismatches;
   int        sent_items;
   bit        calm;

   dir_row_type dir_tab [23] = '{
      '{REQ_TEXT,     4'd0,  5'd0,  8'h78, 6'd0,  1'b1, 1'b1, 1'b1, 1'b0},
      '{REQ_RESERVED, 4'd9,  5'd17, 8'h5A, 6'd40, 1'b1, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_BYTE, 4'd0,  5'd0,  CH_A,  6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_BYTE, 4'd0,  5'd1,  CH_B,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_LEN,  4'd0,  5'd0,  8'h00, 6'd2,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_BYTE, 4'd15, 5'd31, 8'hFF, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_BYTE, 4'd15, 5'd0,  8'h00, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
      // full-length slot; never matches, window stays short until it is disabled below
      '{REQ_PAT_LEN,  4'd15, 5'd0,  8'h00, 6'd32, 1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_LEN,  4'd1,  5'd0,  8'h00, 6'd1,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_LEN,  4'd2,  5'd0,  8'h00, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_TEXT,     4'd0,  5'd0,  CH_A,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_TEXT,     4'd0,  5'd0,  CH_B,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0},
      '{REQ_PAT_BYTE, 4'd3,  5'd0,  CH_A,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_BYTE, 4'd3,  5'd1,  CH_A,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_BYTE, 4'd3,  5'd2,  CH_A,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_PAT_LEN,  4'd3,  5'd0,  8'h00, 6'd3,  1'b0, 1'b1, 1'b0, 1'b0},
      '{REQ_TEXT,     4'd0,  5'd0,  CH_A,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_TEXT,     4'd0,  5'd0,  CH_A,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_TEXT,     4'd0,  5'd0,  CH_A,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
      '{REQ_TEXT,     4'd0,  5'd0,  CH_A,  6'd0,  1'b1, 1'b0, 1'b0, 1'b0},
      '{REQ_TEXT,     4'd15, 5'd31, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b1, 1'b0},
      '{REQ_TEXT,     4'd0,  5'd0,  8'h00, 6'd0,  1'b1, 1'b1, 1'b1, 1'b0},
      '{REQ_PAT_LEN,  4'd15, 5'd31, 8'hFF, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL multi_pattern_match_star_marker_unit");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatches++;
   endtask

   // Advances the predictor by one accepted transaction; released bytes go to fresh_rel.
   function automatic void mark_and_release(input mpm_req_type r);
      int active, k, p, i, pl, base;
      bit hit;
      case (r.kind)
         REQ_PAT_BYTE: begin
            pat_mem[r.slot][r.pos] = r.val;
            seen[r.slot][r.pos] = 1'b1;
         end
         REQ_PAT_LEN: pat_len[r.slot] = (r.plen >= 2 && r.plen <= MAXL) ? r.plen : 6'd0;
         REQ_TEXT: begin
            win_ch[win_fill] = r.val;
            win_star[win_fill] = 1'b0;
            win_fill++;
            active = (slots_on < NP) ? slots_on : NP;
            for (k = 0; k < active; k++) begin
               pl = pat_len[k];
               if (pl >= 2 && pl <= win_fill) begin
                  base = win_fill - pl;
                  hit = 1'b1;
                  for (p = 0; p < pl; p++)
                     if (pat_mem[k][p] != win_ch[base + p]) hit = 1'b0;
                  if (hit)
                     for (i = base; i < win_fill - 1; i++) win_star[i] = 1'b1;
               end
            end
            if (r.last) begin
               for (i = 0; i < win_fill; i++)
                  fresh_rel.insert(fresh_rel.size(),
                                   released_type'{win_ch[i], win_star[i], i == win_fill - 1});
               win_fill = 0;
               foreach (win_star[i]) win_star[i] = 1'b0;
            end else if (win_fill >= MAXL) begin
               // oldest byte leaves with a mark that can no longer change
               fresh_rel.insert(fresh_rel.size(), released_type'{win_ch[0], win_star[0], 1'b0});
               for (i = 0; i < MAXL - 1; i++) begin
                  win_ch[i] = win_ch[i + 1];
                  win_star[i] = win_star[i + 1];
               end
               win_star[MAXL - 1] = 1'b0;
               win_fill--;
            end
         end
         default: ;
      endcase
   endfunction

   // Outside the directed table, a length is only enabled once every byte it covers has been written.
   function automatic bit len_is_safe(input int slot_n, input int want);
      int p;
      if (want < 2 || want > MAXL) return 1'b1;
      for (p = 0; p < want; p++)
         if (!seen[slot_n][p]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return CH_A + 8'($urandom_range(0, 2));
   endfunction

   function automatic mpm_req_type rand_fields(input req_code_type kind);
      mpm_req_type r;
      r.kind = kind;
      r.slot = 4'($urandom_range(0, NP - 1));
      r.pos  = 5'($urandom_range(0, MAXL - 1));
      r.val  = 8'($urandom_range(0, 255));
      r.plen = 6'($urandom_range(0, 63));
      r.last = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic send_req(input mpm_req_type r, input bit lit, input bit lit_res,
                           input bit lit_star);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= r.kind;
      req_chan.pattern_slot <= r.slot;
      req_chan.byte_pos     <= r.pos;
      req_chan.byte_value   <= r.val;
      req_chan.pattern_len  <= r.plen;
      req_chan.last_in      <= r.last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      fresh_rel.delete();
      mark_and_release(r);
      if (lit) begin
         if (lit_res)
            pending_rel.insert(pending_rel.size(), released_type'{r.val, lit_star, 1'b1});
      end else begin
         foreach (fresh_rel[i]) pending_rel.insert(pending_rel.size(), fresh_rel[i]);
      end
      if (r.kind != REQ_RESERVED) sent_items++;
   endtask

   task automatic set_slot_count(input logic [CNT_CFG_W-1:0] v);
      req_chan.valid <= 1'b0;
      while (pending_rel.size() != 0) @(posedge clock);
      // a text byte that releases nothing may still be in the compare loop
      repeat (SETTLE_CYC) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      slots_on = v;
   endtask

   task automatic send_noise();
      mpm_req_type r;
      int want;
      case ($urandom_range(0, 2))
         0: r = rand_fields(REQ_RESERVED);
         1: r = rand_fields(REQ_PAT_BYTE);
         default: begin
            r = rand_fields(REQ_PAT_LEN);
            want = $urandom_range(0, MAXL);
            if (len_is_safe(r.slot, want)) r.plen = 6'(want);
            else if ($urandom_range(0, 1)) r.plen = 6'($urandom_range(MAXL + 1, 63));
            else r.plen = 6'($urandom_range(0, 1));
         end
      endcase
      send_req(r, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic send_pattern_load();
      mpm_req_type r;
      int slot_n, plen_n, p;
      slot_n = $urandom_range(0, NP - 1);
      plen_n = ($urandom_range(0, 11) == 0) ? MAXL : $urandom_range(2, 5);
      for (p = 0; p < plen_n; p++) begin
         r = rand_fields(REQ_PAT_BYTE);
         r.slot = 4'(slot_n);
         r.pos  = 5'(p);
         r.val  = pick_char();
         send_req(r, 1'b0, 1'b0, 1'b0);
      end
      r = rand_fields(REQ_PAT_LEN);
      r.slot = 4'(slot_n);
      r.plen = 6'(plen_n);
      send_req(r, 1'b0, 1'b0, 1'b0);
   endtask

   // Text run built partly from copies of loaded patterns so that matches happen.
   task automatic send_text_run();
      logic [7:0] run_q [$];
      mpm_req_type r;
      int target, k, p;
      bit closing;
      target = ($urandom_range(0, 4) == 0) ? $urandom_range(MAXL + 1, 50)
                                            : $urandom_range(1, 12);
      while (run_q.size() < target) begin
         k = $urandom_range(0, NP - 1);
         if ($urandom_range(0, 2) == 0 && pat_len[k] >= 2) begin
            for (p = 0; p < pat_len[k]; p++) run_q.insert(run_q.size(), pat_mem[k][p]);
         end else begin
            run_q.insert(run_q.size(), pick_char());
         end
      end
      closing = ($urandom_range(0, 9) != 0);
      for (p = 0; p < run_q.size(); p++) begin
         if ($urandom_range(0, 11) == 0) send_noise();
         r = rand_fields(REQ_TEXT);
         r.val  = run_q[p];
         r.last = closing && (p == run_q.size() - 1);
         send_req(r, 1'b0, 1'b0, 1'b0);
      end
   endtask

   task automatic take_release(input released_type got);
      released_type want;
      if (pending_rel.size() == 0) begin
         flag_mismatch($sformatf("unexpected transaction, byte %h", got.ch));
         return;
      end
      want = pending_rel.pop_front();
      if (got.ch !== want.ch)
         flag_mismatch($sformatf("out_byte %h, predicted %h", got.ch, want.ch));
      if (got.star !== want.star)
         flag_mismatch($sformatf("star_after %b on byte %h, predicted %b",
                                 got.star, want.ch, want.star));
      if (got.fin !== want.fin)
         flag_mismatch($sformatf("last_out %b on byte %h, predicted %b",
                                 got.fin, want.ch, want.fin));
   endtask

   initial begin : rsp_side
      int hold;
      released_type got;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.ch   = rsp_chan.out_byte;
            got.star = rsp_chan.star_after;
            got.fin  = rsp_chan.last_out;
            take_release(got);
         end
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 7) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : req_side
      mpm_req_type r;
      int ph, goal, pick;
      logic [CNT_CFG_W-1:0] phase_cnt [6];
      mismatches = 0;
      sent_items = 0;
      calm       = 1'b0;
      win_fill   = 0;
      slots_on   = 0;
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_wdata             <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.req_type     <= REQ_PAT_BYTE;
      req_chan.pattern_slot <= '0;
      req_chan.byte_pos     <= '0;
      req_chan.byte_value   <= '0;
      req_chan.pattern_len  <= '0;
      req_chan.last_in      <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // count above the slot total acts as all slots
      set_slot_count(5'd31);
      foreach (dir_tab[i]) begin
         r.kind = dir_tab[i].kind;
         r.slot = dir_tab[i].slot;
         r.pos  = dir_tab[i].pos;
         r.val  = dir_tab[i].val;
         r.plen = dir_tab[i].plen;
         r.last = dir_tab[i].last;
         send_req(r, dir_tab[i].lit, dir_tab[i].lit_res, dir_tab[i].lit_star);
      end

      phase_cnt[0] = 5'd16;
      phase_cnt[1] = 5'd0;
      phase_cnt[2] = 5'd1;
      phase_cnt[3] = 5'd31;
      phase_cnt[4] = 5'($urandom_range(2, 15));
      phase_cnt[5] = 5'd16;
      for (ph = 0; ph < 6; ph++) begin
         set_slot_count(phase_cnt[ph]);
         calm = (ph == 5);
         goal = sent_items + 35;
         while (sent_items < goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) send_text_run();
            else if (pick < 8) send_pattern_load();
            else send_noise();
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_rel.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS multi_pattern_match_star_marker_unit");
      end else begin
         $display("FAIL multi_pattern_match_star_marker_unit");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/mpmsm_pkg.sv
rtl/mpmsm_req_if.sv
rtl/mpmsm_rsp_if.sv
rtl/mpmsm_datapath.sv
rtl/mpmsm_ctrl.sv
rtl/multi_pattern_match_star_marker_unit.sv
rtl/mpmsm_checker.sv
dv/multi_pattern_match_star_marker_unit_tb.sv
